### hdl/priority_request_queue_defines.svh
// Assertion macros for the priority request queue RTL
`ifndef PRIORITY_REQUEST_QUEUE_DEFINES_SVH
`define PRIORITY_REQUEST_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define PRQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("prq: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset
`define PRQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("prq: next-cycle check failed");

`endif

### hdl/prq_pkg.sv
// Types, codes and reset constants of the priority request queue
`timescale 1ns / 1ps
`default_nettype none
package prq_pkg;

    localparam int DEPTH_DEF       = 1024;
    localparam int PRIO_LEVELS_DEF = 4;

    localparam logic [10:0] MAX_ENTRIES_RST = 11'd1024;
    localparam logic [30:0] DEFAULT_TMO_RST = 31'd30000;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_INVALID = 2'd1;
    localparam logic [1:0] STS_FULL    = 2'd2;
    localparam logic [1:0] STS_EMPTY   = 2'd3;

    localparam logic [7:0] CFG_MAX_ENTRIES = 8'd0;
    localparam logic [7:0] CFG_DEFAULT_TMO = 8'd1;
    localparam logic [7:0] CFG_PRIO_MODE   = 8'd2;
    localparam logic [7:0] CFG_STATS_EN    = 8'd3;

    localparam logic [2:0] SEL_ENQUEUED  = 3'd0;
    localparam logic [2:0] SEL_DEQUEUED  = 3'd1;
    localparam logic [2:0] SEL_DROPPED   = 3'd2;
    localparam logic [2:0] SEL_TIMED_OUT = 3'd3;
    localparam logic [2:0] SEL_PEAK      = 3'd4;
    localparam logic [2:0] SEL_WAIT      = 3'd5;

    typedef enum logic [3:0] {
        ACT_ENQUEUE      = 4'd0,
        ACT_DEQUEUE      = 4'd1,
        ACT_CANCEL       = 4'd2,
        ACT_FIND         = 4'd3,
        ACT_SET_TIMEOUT  = 4'd4,
        ACT_EXPIRE       = 4'd5,
        ACT_TICK         = 4'd6,
        ACT_CLEAR        = 4'd7,
        ACT_READ_COUNTER = 4'd8
    } action_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [10:0] max_entries;
        logic [30:0] default_tmo;
        logic        prio_mode;
        logic        stats_en;
    } cfg_t;

    // Input beat fields, first field in the highest bits
    typedef struct packed {
        logic [2:0]  sel;
        logic [7:0]  worker;
        logic [31:0] target;
        logic [30:0] tmo;
        logic [1:0]  prio;
        logic [15:0] payload;
        logic [15:0] client;
    } cmd_t;

    // One queue slot
    typedef struct packed {
        logic [47:0] submit;
        logic [30:0] timeout;
        logic [1:0]  prio;
        logic [15:0] payload;
        logic [15:0] client;
        logic [31:0] id;
    } entry_t;

    // Result beat fields, first field in the highest bits
    typedef struct packed {
        logic [10:0] qsize;
        logic [47:0] count;
        logic [47:0] wait_ms;
        logic [7:0]  worker;
        logic [30:0] timeout;
        logic [1:0]  prio;
        logic [15:0] payload;
        logic [15:0] client;
        logic [31:0] id;
        logic [1:0]  status;
    } res_t;

endpackage
`default_nettype wire

### hdl/prq_slot_ram.sv
// Slot memory: one write port, one read port, registered read data
`timescale 1ns / 1ps
`default_nettype none
module prq_slot_ram
    import prq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire entry_t        wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output entry_t             rd_data
);

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

### hdl/prq_engine.sv
// Sequencer: walks the slot memory to insert, compact, search and expire
`timescale 1ns / 1ps
`default_nettype none
module prq_engine
    import prq_pkg::*;
#(
    parameter int DEPTH           = DEPTH_DEF,
    parameter int PRIORITY_LEVELS = PRIO_LEVELS_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [3:0] in_action,
    input  wire cmd_t       in_cmd,
    input  wire logic       res_free,
    output logic            res_valid,
    output res_t            res
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    state_t       state_reg, state_next;
    logic [3:0]   act_reg, act_next;
    cmd_t         cmd_reg, cmd_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]  next_id_reg, next_id_next;
    logic [47:0]  now_reg, now_next;
    logic [47:0]  ev_reg [4];
    logic [47:0]  ev_next [4];
    logic [CW-1:0] peak_reg, peak_next;
    logic [47:0]  wait_tot_reg, wait_tot_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] wr_reg, wr_next;
    logic [CW-1:0] exp_reg, exp_next;
    logic         hit_reg, hit_next;
    entry_t       carry_reg, carry_next;
    res_t         res_reg, res_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    entry_t        ram_wdata, ram_rdata;

    logic [31:0]   cap;
    logic          full;
    logic [1:0]    prio_sat;
    logic [47:0]   elapsed;
    logic [CW-1:0] count_inc;
    entry_t        new_entry;
    entry_t        retimed;

    function automatic res_t report(input res_t r, input entry_t e);
        res_t o;
        o         = r;
        o.id      = e.id;
        o.client  = e.client;
        o.payload = e.payload;
        o.prio    = e.prio;
        o.timeout = e.timeout;
        return o;
    endfunction

    prq_slot_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        cap = 32'(cfg.max_entries);
        if (cap < 32'd1)
        begin
            cap = 32'd1;
        end
        if (cap > 32'(DEPTH))
        begin
            cap = 32'(DEPTH);
        end
    end

    assign full      = (32'(count_reg) >= cap);
    assign prio_sat  = (32'(in_cmd.prio) > 32'(PRIORITY_LEVELS - 1)) ?
                       2'(PRIORITY_LEVELS - 1) : in_cmd.prio;
    assign elapsed   = now_reg - ram_rdata.submit;
    assign count_inc = count_reg + CW'(1);

    always_comb
    begin
        new_entry.id      = next_id_reg;
        new_entry.client  = in_cmd.client;
        new_entry.payload = in_cmd.payload;
        new_entry.prio    = prio_sat;
        new_entry.timeout = (in_cmd.tmo == 31'd0) ? cfg.default_tmo : in_cmd.tmo;
        new_entry.submit  = now_reg;
        retimed           = ram_rdata;
        retimed.timeout   = cmd_reg.tmo;
    end

    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        cmd_next      = cmd_reg;
        count_next    = count_reg;
        next_id_next  = next_id_reg;
        now_next      = now_reg;
        ev_next       = ev_reg;
        peak_next     = peak_reg;
        wait_tot_next = wait_tot_reg;
        idx_next      = idx_reg;
        wr_next       = wr_reg;
        exp_next      = exp_reg;
        hit_next      = hit_reg;
        carry_next    = carry_reg;
        res_next      = res_reg;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = wr_reg[AW-1:0];
        ram_wdata     = ram_rdata;
        ram_raddr     = idx_reg[AW-1:0];
        in_ready      = (state_reg == S_IDLE);
        res_valid     = 1'b0;
        res           = res_reg;
        res.qsize     = 11'(count_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next        = in_action;
                    cmd_next        = in_cmd;
                    cmd_next.prio   = prio_sat;
                    res_next        = '0;
                    res_next.status = STS_OK;
                    idx_next        = '0;
                    wr_next         = '0;
                    exp_next        = '0;
                    hit_next        = 1'b0;
                    state_next      = S_DONE;
                    case (in_action)
                        ACT_ENQUEUE:
                        begin
                            if (in_cmd.client == 16'd0 || in_cmd.payload == 16'd0)
                            begin
                                res_next.status = STS_INVALID;
                            end
                            else if (full)
                            begin
                                if (cfg.stats_en)
                                begin
                                    ev_next[2] = ev_reg[2] + 48'd1;
                                end
                                res_next.status = STS_FULL;
                            end
                            else
                            begin
                                carry_next   = new_entry;
                                res_next.id  = next_id_reg;
                                next_id_next = next_id_reg + 32'd1;
                                if (cfg.prio_mode)
                                begin
                                    state_next = S_READ;
                                end
                                else
                                begin
                                    ram_we     = 1'b1;
                                    ram_waddr  = count_reg[AW-1:0];
                                    ram_wdata  = new_entry;
                                    count_next = count_inc;
                                    if (cfg.stats_en)
                                    begin
                                        ev_next[0] = ev_reg[0] + 48'd1;
                                        if (count_inc > peak_reg)
                                        begin
                                            peak_next = count_inc;
                                        end
                                    end
                                end
                            end
                        end
                        ACT_DEQUEUE:
                        begin
                            if (count_reg == '0)
                            begin
                                res_next.status = STS_EMPTY;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        ACT_CANCEL, ACT_FIND, ACT_SET_TIMEOUT, ACT_EXPIRE:
                        begin
                            state_next = S_READ;
                        end
                        ACT_TICK:
                        begin
                            now_next = now_reg + 48'd1;
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ACT_READ_COUNTER:
                        begin
                            case (in_cmd.sel)
                                SEL_ENQUEUED, SEL_DEQUEUED, SEL_DROPPED, SEL_TIMED_OUT:
                                begin
                                    res_next.count = ev_reg[in_cmd.sel[1:0]];
                                end
                                SEL_PEAK:
                                begin
                                    res_next.count = 48'(peak_reg);
                                end
                                SEL_WAIT:
                                begin
                                    res_next.count = wait_tot_reg;
                                end
                                default:
                                begin
                                    res_next.status = STS_INVALID;
                                end
                            endcase
                        end
                        default:
                        begin
                            res_next.status = STS_INVALID;
                        end
                    endcase
                end
            end

            S_READ:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = S_DONE;
                    case (act_reg)
                        ACT_ENQUEUE:
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = idx_reg[AW-1:0];
                            ram_wdata  = carry_reg;
                            count_next = count_inc;
                            if (cfg.stats_en)
                            begin
                                ev_next[0] = ev_reg[0] + 48'd1;
                                if (count_inc > peak_reg)
                                begin
                                    peak_next = count_inc;
                                end
                            end
                        end
                        ACT_DEQUEUE:
                        begin
                            count_next = wr_reg;
                        end
                        ACT_CANCEL:
                        begin
                            count_next = wr_reg;
                            if (!hit_reg)
                            begin
                                res_next.status = STS_INVALID;
                            end
                        end
                        ACT_EXPIRE:
                        begin
                            count_next     = wr_reg;
                            res_next.count = 48'(exp_reg);
                        end
                        default:
                        begin
                            // find or set timeout ran off the tail
                            res_next.status = STS_INVALID;
                        end
                    endcase
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                idx_next   = idx_reg + CW'(1);
                state_next = S_READ;
                case (act_reg)
                    ACT_ENQUEUE:
                    begin
                        // once past the insert point, ripple each slot down one place
                        if (hit_reg || ram_rdata.prio < carry_reg.prio)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = idx_reg[AW-1:0];
                            ram_wdata  = carry_reg;
                            carry_next = ram_rdata;
                            hit_next   = 1'b1;
                        end
                    end
                    ACT_DEQUEUE:
                    begin
                        if (idx_reg == '0)
                        begin
                            res_next         = report(res_reg, ram_rdata);
                            res_next.worker  = cmd_reg.worker;
                            res_next.wait_ms = elapsed;
                            if (cfg.stats_en)
                            begin
                                ev_next[1]    = ev_reg[1] + 48'd1;
                                wait_tot_next = wait_tot_reg + elapsed;
                            end
                        end
                        else
                        begin
                            ram_we  = 1'b1;
                            wr_next = wr_reg + CW'(1);
                        end
                    end
                    ACT_CANCEL:
                    begin
                        if (!hit_reg && ram_rdata.id == cmd_reg.target)
                        begin
                            hit_next    = 1'b1;
                            res_next.id = cmd_reg.target;
                        end
                        else
                        begin
                            ram_we  = 1'b1;
                            wr_next = wr_reg + CW'(1);
                        end
                    end
                    ACT_EXPIRE:
                    begin
                        if (elapsed > 48'(ram_rdata.timeout))
                        begin
                            exp_next = exp_reg + CW'(1);
                            if (cfg.stats_en)
                            begin
                                ev_next[3] = ev_reg[3] + 48'd1;
                            end
                        end
                        else
                        begin
                            ram_we  = 1'b1;
                            wr_next = wr_reg + CW'(1);
                        end
                    end
                    ACT_FIND:
                    begin
                        if (ram_rdata.id == cmd_reg.target)
                        begin
                            res_next   = report(res_reg, ram_rdata);
                            state_next = S_DONE;
                        end
                    end
                    ACT_SET_TIMEOUT:
                    begin
                        if (ram_rdata.id == cmd_reg.target)
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = idx_reg[AW-1:0];
                            ram_wdata  = retimed;
                            res_next   = report(res_reg, retimed);
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_DONE:
            begin
                if (res_free)
                begin
                    res_valid  = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            next_id_reg  <= 32'd1;
            now_reg      <= '0;
            ev_reg       <= '{default: '0};
            peak_reg     <= '0;
            wait_tot_reg <= '0;
            idx_reg      <= '0;
            wr_reg       <= '0;
            exp_reg      <= '0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            next_id_reg  <= next_id_next;
            now_reg      <= now_next;
            ev_reg       <= ev_next;
            peak_reg     <= peak_next;
            wait_tot_reg <= wait_tot_next;
            idx_reg      <= idx_next;
            wr_reg       <= wr_next;
            exp_reg      <= exp_next;
            hit_reg      <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        cmd_reg   <= cmd_next;
        carry_reg <= carry_next;
        res_reg   <= res_next;
    end

endmodule
`default_nettype wire

### hdl/priority_request_queue.sv
// Top level of the priority request queue: config registers, result register
//
// Usage:
//  - Command beats enter on the s_ stream; s_tuser carries the action code and
//    s_tdata the operands. Exactly one result beat leaves on the m_ stream per
//    command, in command order.
//  - Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
//    cfg_ready is always high. Write only while no command is in flight.
//  - Tick, clear, counter read and rejected commands go from accept straight
//    to the result, with no slot walk. Enqueue in FIFO mode does so as well.
//  - Priority enqueue, dequeue, cancel, find, set timeout and expire walk the
//    slot memory one slot at a time (read, then evaluate and write back),
//    over the N entries held, at most DEPTH. Find and set timeout stop at
//    the first match.
//  - One command is worked at a time; the next is taken once the result has
//    moved to the output register, even while that beat is still stalled.
//  - A stalled m_tready holds the result beat and, after the next command
//    finishes, holds the sequencer too.
//  - Reset empties the queue, sets the next id to 1, clears time and all
//    statistics, and restores the configuration defaults. No clearing pass
//    runs over the slot memory, since slots beyond the fill count are never read.
`timescale 1ns / 1ps
`default_nettype none
`include "priority_request_queue_defines.svh"
module priority_request_queue
    import prq_pkg::*;
#(
    parameter int DEPTH           = DEPTH_DEF,
    parameter int PRIORITY_LEVELS = PRIO_LEVELS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    // command beat
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // client_handle, payload_handle, priority_req, timeout, target_id,
    // worker, counter_select, zero pad
    input  wire logic [111:0] s_tdata,
    // action
    input  wire logic [3:0]   s_tuser,
    // result beat
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // status, result_id, result_client, result_payload, result_priority,
    // result_timeout, result_worker, wait_ms, count_value, queue_size, zero pad
    output logic [215:0]      m_tdata,
    // configuration writes
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [7:0]   cfg_index,
    input  wire logic [30:0]  cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic out_valid_reg, out_valid_next;
    res_t out_data_reg;
    logic res_free;
    logic res_valid;
    res_t res;

    assign cfg_ready = 1'b1;

    // Decode a config write; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAX_ENTRIES: cfg_next.max_entries = cfg_data[10:0];
                CFG_DEFAULT_TMO: cfg_next.default_tmo = cfg_data;
                CFG_PRIO_MODE:   cfg_next.prio_mode   = cfg_data[0];
                CFG_STATS_EN:    cfg_next.stats_en    = cfg_data[0];
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_entries <= MAX_ENTRIES_RST;
            cfg_reg.default_tmo <= DEFAULT_TMO_RST;
            cfg_reg.prio_mode   <= 1'b1;
            cfg_reg.stats_en    <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    prq_engine #(.DEPTH(DEPTH), .PRIORITY_LEVELS(PRIORITY_LEVELS)) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_action (s_tuser),
        .in_cmd    (cmd_t'(s_tdata[107:0])),
        .res_free  (res_free),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output register: load when free, drop the beat once taken
    assign res_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

    `PRQ_ASSERT_IMPL(a_qsize_bound, m_tvalid, 32'(out_data_reg.qsize) <= 32'(DEPTH))
    `PRQ_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `PRQ_ASSERT_IMPL(a_no_overwrite, res_valid, !out_valid_reg || m_tready)

endmodule
`default_nettype wire

### tb/priority_request_queue_tb.sv
// Self-checking testbench for the priority request queue: random and directed command beats
`timescale 1ns / 1ps
module priority_request_queue_tb;
    import prq_pkg::*;

    localparam int MEM_DEPTH = 1024;

    // Pending command beat: action code plus operand fields
    typedef struct {
        logic [3:0] act;
        cmd_t       cmd;
    } pend_cmd_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [3:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [215:0] m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [7:0]   cfg_index = '0;
    logic [30:0]  cfg_data = '0;

    priority_request_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // Shadow of the queue contents and counters, updated on every accepted beat
    entry_t      shadow_slots[$];
    logic [31:0] shadow_next_id;
    logic [47:0] shadow_now;
    logic [47:0] shadow_events[4];
    logic [10:0] shadow_peak;
    logic [47:0] shadow_wait_total;
    cfg_t        shadow_cfg;

    pend_cmd_t   cmd_backlog[$];   // beats waiting to be driven
    res_t        expected_res[$];  // results predicted, oldest first
    int          mismatch_count = 0;
    int          idle_pct = 38;
    bit          cmd_fire = 1'b0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Capacity in use: 0 acts as 1, anything above the built depth is clamped
    function automatic int queue_capacity();
        int c;
        c = shadow_cfg.max_entries;
        if (c < 1) c = 1;
        if (c > MEM_DEPTH) c = MEM_DEPTH;
        return c;
    endfunction

    // Apply one command to the shadow queue and return the result it causes
    function automatic res_t apply_command(logic [3:0] act, cmd_t c);
        res_t        r;
        entry_t      e;
        entry_t      kept[$];
        int          pos;
        int          j;
        logic [30:0] tmo;
        logic [47:0] waited;
        logic [47:0] expired;
        r = '0;
        pos = -1;
        if (act inside {ACT_CANCEL, ACT_FIND, ACT_SET_TIMEOUT})
        begin
            for (int i = 0; i < shadow_slots.size(); i++)
                if (pos < 0 && shadow_slots[i].id == c.target) pos = i;
        end
        case (act)
            ACT_ENQUEUE:
            begin
                if (c.client == 16'd0 || c.payload == 16'd0)
                    r.status = STS_INVALID;
                else if (shadow_slots.size() >= queue_capacity())
                begin
                    if (shadow_cfg.stats_en) shadow_events[2] = shadow_events[2] + 48'd1;
                    r.status = STS_FULL;
                end
                else
                begin
                    tmo = (c.tmo == 31'd0) ? shadow_cfg.default_tmo : c.tmo;
                    j = shadow_slots.size();
                    if (shadow_cfg.prio_mode)
                    begin
                        j = 0;
                        while (j < shadow_slots.size() && shadow_slots[j].prio >= c.prio) j++;
                    end
                    e.id = shadow_next_id;
                    e.client = c.client;
                    e.payload = c.payload;
                    e.prio = c.prio;
                    e.timeout = tmo;
                    e.submit = shadow_now;
                    shadow_slots.insert(j, e);
                    r.id = shadow_next_id;
                    shadow_next_id = shadow_next_id + 32'd1;
                    if (shadow_cfg.stats_en)
                    begin
                        shadow_events[0] = shadow_events[0] + 48'd1;
                        if (11'(shadow_slots.size()) > shadow_peak)
                            shadow_peak = 11'(shadow_slots.size());
                    end
                end
            end
            ACT_DEQUEUE:
            begin
                if (shadow_slots.size() == 0)
                    r.status = STS_EMPTY;
                else
                begin
                    e = shadow_slots.pop_front();
                    r.id = e.id;
                    r.client = e.client;
                    r.payload = e.payload;
                    r.prio = e.prio;
                    r.timeout = e.timeout;
                    r.worker = c.worker;
                    waited = shadow_now - e.submit;
                    r.wait_ms = waited;
                    if (shadow_cfg.stats_en)
                    begin
                        shadow_events[1] = shadow_events[1] + 48'd1;
                        shadow_wait_total = shadow_wait_total + waited;
                    end
                end
            end
            ACT_CANCEL, ACT_FIND, ACT_SET_TIMEOUT:
            begin
                if (pos < 0)
                    r.status = STS_INVALID;
                else if (act == ACT_CANCEL)
                begin
                    r.id = c.target;
                    shadow_slots.delete(pos);
                end
                else
                begin
                    if (act == ACT_SET_TIMEOUT) shadow_slots[pos].timeout = c.tmo;
                    e = shadow_slots[pos];
                    r.id = e.id;
                    r.client = e.client;
                    r.payload = e.payload;
                    r.prio = e.prio;
                    r.timeout = e.timeout;
                end
            end
            ACT_EXPIRE:
            begin
                expired = '0;
                foreach (shadow_slots[i])
                begin
                    waited = shadow_now - shadow_slots[i].submit;
                    if (waited > {17'd0, shadow_slots[i].timeout})
                    begin
                        expired = expired + 48'd1;
                        if (shadow_cfg.stats_en) shadow_events[3] = shadow_events[3] + 48'd1;
                    end
                    else
                        kept.push_back(shadow_slots[i]);
                end
                shadow_slots = kept;
                r.count = expired;
            end
            ACT_TICK:
                shadow_now = shadow_now + 48'd1;
            ACT_CLEAR:
                shadow_slots.delete();
            ACT_READ_COUNTER:
            begin
                if (c.sel < 3'd4) r.count = shadow_events[c.sel[1:0]];
                else if (c.sel == SEL_PEAK) r.count = {37'd0, shadow_peak};
                else if (c.sel == SEL_WAIT) r.count = shadow_wait_total;
                else r.status = STS_INVALID;
            end
            default:
                r.status = STS_INVALID;
        endcase
        r.qsize = 11'(shadow_slots.size());
        return r;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Monitor: sample the command, result and config handshakes at the rising edge
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        cmd_fire = s_tvalid && s_tready;
        if (rst_n && cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_MAX_ENTRIES: shadow_cfg.max_entries = cfg_data[10:0];
                CFG_DEFAULT_TMO: shadow_cfg.default_tmo = cfg_data;
                CFG_PRIO_MODE:   shadow_cfg.prio_mode = cfg_data[0];
                CFG_STATS_EN:    shadow_cfg.stats_en = cfg_data[0];
                default: ;
            endcase
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            got = res_t'(m_tdata[213:0]);
            if (expected_res.size() == 0)
            begin
                $display("%0t: unexpected result beat, actual %0h", $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want = expected_res.pop_front();
                check_field("status", want.status, got.status);
                check_field("result_id", want.id, got.id);
                check_field("result_client", want.client, got.client);
                check_field("result_payload", want.payload, got.payload);
                check_field("result_priority", want.prio, got.prio);
                check_field("result_timeout", want.timeout, got.timeout);
                check_field("result_worker", want.worker, got.worker);
                check_field("wait_ms", want.wait_ms, got.wait_ms);
                check_field("count_value", want.count, got.count);
                check_field("queue_size", want.qsize, got.qsize);
                check_field("pad", 64'd0, m_tdata[215:214]);
            end
        end
        if (rst_n && cmd_fire)
            expected_res.push_back(apply_command(s_tuser, cmd_t'(s_tdata[107:0])));
    end

    // Driver: change inputs at the falling edge, hold a beat until accepted
    always @(negedge clk)
    begin
        pend_cmd_t p;
        if (rst_n)
        begin
            if (s_tvalid && !cmd_fire)
                ;
            else if (cmd_backlog.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                p = cmd_backlog.pop_front();
                s_tuser <= p.act;
                s_tdata <= {4'd0, p.cmd};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    task automatic send_cmd(logic [3:0] act, logic [15:0] client, logic [15:0] payload,
                            logic [1:0] prio, logic [30:0] tmo, logic [31:0] target,
                            logic [7:0] worker, logic [2:0] sel);
        pend_cmd_t p;
        p.act = act;
        p.cmd.client = client;
        p.cmd.payload = payload;
        p.cmd.prio = prio;
        p.cmd.tmo = tmo;
        p.cmd.target = target;
        p.cmd.worker = worker;
        p.cmd.sel = sel;
        cmd_backlog.push_back(p);
    endtask

    // Build one random beat from the current shadow contents so ids mostly hit
    task automatic send_random_cmd();
        int          pick;
        logic [3:0]  act;
        logic [15:0] client;
        logic [15:0] payload;
        logic [30:0] tmo;
        logic [31:0] target;
        pick = $urandom_range(99);
        if (pick < 35) act = ACT_ENQUEUE;
        else if (pick < 50) act = ACT_DEQUEUE;
        else if (pick < 58) act = ACT_CANCEL;
        else if (pick < 66) act = ACT_FIND;
        else if (pick < 72) act = ACT_SET_TIMEOUT;
        else if (pick < 80) act = ACT_EXPIRE;
        else if (pick < 92) act = ACT_TICK;
        else if (pick < 94) act = ACT_CLEAR;
        else if (pick < 98) act = ACT_READ_COUNTER;
        else act = 4'($urandom_range(15, 9));
        client = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom);
        payload = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 30) tmo = '0;
        else if (pick < 80) tmo = 31'($urandom_range(6));
        else if (pick < 95) tmo = 31'($urandom);
        else tmo = '1;
        if (shadow_slots.size() > 0 && $urandom_range(99) < 75)
            target = shadow_slots[$urandom_range(shadow_slots.size() - 1)].id;
        else
            target = 32'($urandom);
        send_cmd(act, client, payload, 2'($urandom), tmo, target, 8'($urandom),
                 3'($urandom_range(7)));
    endtask

    task automatic write_cfg(logic [7:0] idx, logic [30:0] data);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= data;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Hold until every beat is sent and every result has come back
    task automatic wait_drained();
        @(posedge clk);
        while (cmd_backlog.size() != 0 || s_tvalid || expected_res.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [10:0] caps[6]  = '{11'd4, 11'd1, 11'd0, 11'd2047, 11'd16, 11'd8};
        logic [30:0] dflts[6] = '{31'd0, 31'h7fffffff, 31'd3, 31'd30000, 31'd0, 31'd5};
        bit          modes[6] = '{1, 0, 1, 1, 0, 1};
        bit          stats[6] = '{1, 0, 1, 0, 1, 1};
        int          sent;
        shadow_slots.delete();
        shadow_next_id = 32'd1;
        shadow_now = '0;
        foreach (shadow_events[i]) shadow_events[i] = '0;
        shadow_peak = '0;
        shadow_wait_total = '0;
        shadow_cfg.max_entries = MAX_ENTRIES_RST;
        shadow_cfg.default_tmo = DEFAULT_TMO_RST;
        shadow_cfg.prio_mode = 1'b1;
        shadow_cfg.stats_en = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty dequeue, bad handles, every priority, field extremes
        send_cmd(ACT_DEQUEUE, 16'd1, 16'd1, 2'd0, 31'd0, 32'd0, 8'hff, 3'd0);
        send_cmd(ACT_ENQUEUE, 16'd0, 16'd5, 2'd1, 31'd0, 32'd0, 8'd0, 3'd0);
        send_cmd(ACT_ENQUEUE, 16'd5, 16'd0, 2'd1, 31'd0, 32'd0, 8'd0, 3'd0);
        send_cmd(ACT_ENQUEUE, 16'd1, 16'd1, 2'd0, 31'd0, 32'd0, 8'd0, 3'd0);
        send_cmd(ACT_ENQUEUE, 16'hffff, 16'hffff, 2'd3, 31'h7fffffff, 32'hffffffff,
                 8'hff, 3'd7);
        send_cmd(ACT_ENQUEUE, 16'd2, 16'd3, 2'd1, 31'd1, 32'd0, 8'd0, 3'd0);
        send_cmd(ACT_ENQUEUE, 16'd4, 16'd9, 2'd2, 31'd2, 32'd0, 8'd0, 3'd0);
        send_cmd(ACT_ENQUEUE, 16'd6, 16'd7, 2'd3, 31'd0, 32'd0, 8'd0, 3'd0);
        send_cmd(ACT_FIND, 16'd0, 16'd0, 2'd0, 31'd0, 32'd3, 8'd0, 3'd0);
        send_cmd(ACT_FIND, 16'd0, 16'd0, 2'd0, 31'd0, 32'hffffffff, 8'd0, 3'd0);
        send_cmd(ACT_SET_TIMEOUT, 16'd0, 16'd0, 2'd0, 31'd0, 32'd4, 8'd0, 3'd0);
        send_cmd(ACT_SET_TIMEOUT, 16'd0, 16'd0, 2'd0, 31'd0, 32'd99, 8'd0, 3'd0);
        send_cmd(ACT_CANCEL, 16'd0, 16'd0, 2'd0, 31'd0, 32'd2, 8'd0, 3'd0);
        send_cmd(ACT_CANCEL, 16'd0, 16'd0, 2'd0, 31'd0, 32'd2, 8'd0, 3'd0);
        send_cmd(ACT_TICK, 16'd0, 16'd0, 2'd0, 31'd0, 32'd0, 8'd0, 3'd0);
        send_cmd(ACT_TICK, 16'd0, 16'd0, 2'd0, 31'd0, 32'd0, 8'd0, 3'd0);
        send_cmd(ACT_EXPIRE, 16'd0, 16'd0, 2'd0, 31'd0, 32'd0, 8'd0, 3'd0);
        send_cmd(ACT_DEQUEUE, 16'd0, 16'd0, 2'd0, 31'd0, 32'd0, 8'h5a, 3'd0);
        for (int s = 0; s < 8; s++)
            send_cmd(ACT_READ_COUNTER, 16'd0, 16'd0, 2'd0, 31'd0, 32'd0, 8'd0, s[2:0]);
        send_cmd(4'd9, 16'd1, 16'd1, 2'd0, 31'd0, 32'd0, 8'd0, 3'd0);
        send_cmd(4'd15, 16'd1, 16'd1, 2'd0, 31'd0, 32'd0, 8'd0, 3'd0);
        send_cmd(ACT_CLEAR, 16'd0, 16'd0, 2'd0, 31'd0, 32'd0, 8'd0, 3'd0);

        // Random phases, each under its own register setting
        sent = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            wait_drained();
            write_cfg(CFG_MAX_ENTRIES, {20'd0, caps[ph]});
            write_cfg(CFG_DEFAULT_TMO, dflts[ph]);
            write_cfg(CFG_PRIO_MODE, {30'd0, modes[ph]});
            write_cfg(CFG_STATS_EN, {30'd0, stats[ph]});
            @(negedge clk);
            cfg_valid <= 1'b0;
            for (int n = 0; n < 93; n++)
            begin
                // Keep one long stretch with no idling on either side
                idle_pct = (sent >= 200 && sent < 330) ? 0 : 38;
                @(posedge clk);
                while (cmd_backlog.size() != 0) @(posedge clk);
                send_random_cmd();
                sent++;
            end
        end

        wait_drained();
        repeat (2 * MEM_DEPTH + 16) @(posedge clk);
        if (mismatch_count == 0 && expected_res.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
